>>> rtl/mbtcp_pkg.sv
// Shared types, constants and function codes of the Modbus TCP request framer.
package mbtcp_pkg;

  // Default limit on the data bytes of one multi-write frame.
  localparam int MAX_DATA_BYTES_DEF = 240;

  // Depth of the command queue between the front and the back.
  localparam int QDEPTH = 4;

  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_DATA   = 1'b1;

  localparam logic [4:0] FC_READ_COILS      = 5'd1;
  localparam logic [4:0] FC_READ_DISCRETE   = 5'd2;
  localparam logic [4:0] FC_READ_HOLDING    = 5'd3;
  localparam logic [4:0] FC_READ_INPUT      = 5'd4;
  localparam logic [4:0] FC_WRITE_COIL      = 5'd5;
  localparam logic [4:0] FC_WRITE_REGISTER  = 5'd6;
  localparam logic [4:0] FC_WRITE_COILS     = 5'd15;
  localparam logic [4:0] FC_WRITE_REGISTERS = 5'd16;

  localparam logic [19:0] ADDR_COIL_LO     = 20'd1;
  localparam logic [19:0] ADDR_COIL_END    = 20'd10000;
  localparam logic [19:0] ADDR_DISC_LO     = 20'd10001;
  localparam logic [19:0] ADDR_DISC_END    = 20'd20000;
  localparam logic [19:0] ADDR_INREG_LO    = 20'd30001;
  localparam logic [19:0] ADDR_INREG_HI    = 20'd39999;
  localparam logic [19:0] ADDR_HOLD_LO     = 20'd40001;
  localparam logic [19:0] ADDR_HOLD_HI     = 20'd49999;
  localparam logic [19:0] ADDR_INREG_XBASE = 20'd300001;
  localparam logic [19:0] ADDR_HOLD_XBASE  = 20'd400001;
  localparam logic [19:0] ADDR_INREG_XLO   = 20'd310000;
  localparam logic [19:0] ADDR_HOLD_XLO    = 20'd410000;
  localparam logic [19:0] ADDR_INREG_XHI   = 20'd365536;
  localparam logic [19:0] ADDR_HOLD_XHI    = 20'd465536;

  localparam logic [15:0] COIL_ON   = 16'hFF00;
  localparam logic [15:0] COIL_OFF  = 16'h0000;
  localparam logic [2:0]  TAIL_MASK = 3'h7;

  // Byte positions within a header burst.
  localparam logic [3:0] HDR_LAST_SINGLE = 4'd11;
  localparam logic [3:0] HDR_LAST_MULTI  = 4'd12;

  typedef enum logic [1:0] {
    CMD_ERR,
    CMD_HDR,
    CMD_DATA
  } cmd_kind_e;

  // One unit of work for the serializer: an error, a header burst or data bytes.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [3:0]  end_idx;
    logic        fin_last;
    logic [15:0] tid;
    logic [8:0]  len;
    logic [7:0]  unit;
    logic [4:0]  fc;
    logic [15:0] off;
    logic [15:0] word;
    logic [7:0]  nbytes;
  } cmd_t;

endpackage

>>> rtl/mbtcp_front.sv
// Front end: accepts request and data items, classifies them and tracks the pending write.
module mbtcp_front #(
  parameter int MAX_DATA_BYTES = mbtcp_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               mode_i,
  input  logic               write_request_i,
  input  logic [19:0]        address_i,
  input  logic [15:0]        item_count_i,
  input  logic [7:0]         unit_id_i,
  input  logic [15:0]        transaction_id_i,
  input  logic [15:0]        data_word_i,
  output logic               cmd_push_o,
  output mbtcp_pkg::cmd_t    cmd_o
);
  import mbtcp_pkg::*;

  localparam int MaxCount = 8 * MAX_DATA_BYTES;

  logic       awaiting_q, awaiting_d;
  logic [4:0] pend_fc_q, pend_fc_d;
  logic [7:0] rem_q, rem_d;
  logic [2:0] tail_q, tail_d;

  logic        req_err;
  logic [4:0]  req_fc;
  logic [19:0] off_full;
  logic [15:0] req_word;
  logic [16:0] nbytes_full;
  logic        is_multi;
  logic        in_coil, in_disc, in_inreg_s, in_inreg_x, in_hold_s, in_hold_x;

  assign in_coil    = (address_i >= ADDR_COIL_LO) && (address_i < ADDR_COIL_END);
  assign in_disc    = (address_i >= ADDR_DISC_LO) && (address_i < ADDR_DISC_END);
  assign in_inreg_s = (address_i >= ADDR_INREG_LO) && (address_i <= ADDR_INREG_HI);
  assign in_inreg_x = (address_i >= ADDR_INREG_XLO) && (address_i <= ADDR_INREG_XHI);
  assign in_hold_s  = (address_i >= ADDR_HOLD_LO) && (address_i <= ADDR_HOLD_HI);
  assign in_hold_x  = (address_i >= ADDR_HOLD_XLO) && (address_i <= ADDR_HOLD_XHI);

  // Request classification: function code, offset, word and data byte count.
  always_comb begin
    req_err     = 1'b0;
    req_fc      = FC_READ_COILS;
    off_full    = '0;
    req_word    = item_count_i;
    nbytes_full = '0;
    if ((item_count_i == 16'd0) || (item_count_i > 16'(MaxCount))) begin
      req_err = 1'b1;
    end
    priority if (in_coil) begin
      off_full = address_i - ADDR_COIL_LO;
      if (write_request_i) begin
        req_fc = (item_count_i == 16'd1) ? FC_WRITE_COIL : FC_WRITE_COILS;
      end else begin
        req_fc = FC_READ_COILS;
      end
    end else if (in_disc) begin
      off_full = address_i - ADDR_DISC_LO;
      req_fc   = FC_READ_DISCRETE;
      if (write_request_i) begin
        req_err = 1'b1;
      end
    end else if (in_inreg_s || in_inreg_x) begin
      off_full = in_inreg_s ? (address_i - ADDR_INREG_LO) : (address_i - ADDR_INREG_XBASE);
      req_fc   = FC_READ_INPUT;
      if (write_request_i) begin
        req_err = 1'b1;
      end
    end else if (in_hold_s || in_hold_x) begin
      off_full = in_hold_s ? (address_i - ADDR_HOLD_LO) : (address_i - ADDR_HOLD_XBASE);
      if (write_request_i) begin
        req_fc = (item_count_i == 16'd1) ? FC_WRITE_REGISTER : FC_WRITE_REGISTERS;
      end else begin
        req_fc = FC_READ_HOLDING;
      end
    end else begin
      req_err = 1'b1;
    end
    if (req_fc == FC_WRITE_COIL) begin
      req_word = data_word_i[0] ? COIL_ON : COIL_OFF;
    end else if (req_fc == FC_WRITE_REGISTER) begin
      req_word = data_word_i;
    end
    if (req_fc == FC_WRITE_COILS) begin
      nbytes_full = (17'(item_count_i) + 17'd7) >> 3;
    end else if (req_fc == FC_WRITE_REGISTERS) begin
      nbytes_full = {item_count_i, 1'b0};
    end
    if (nbytes_full > 17'(MAX_DATA_BYTES)) begin
      req_err = 1'b1;
    end
  end

  assign is_multi = (req_fc == FC_WRITE_COILS) || (req_fc == FC_WRITE_REGISTERS);

  always_comb begin
    logic [7:0] rem_next;
    logic [7:0] coil_byte;
    rem_next   = '0;
    coil_byte  = data_word_i[7:0];
    cmd_o      = '0;
    cmd_push_o = 1'b0;
    awaiting_d = awaiting_q;
    pend_fc_d  = pend_fc_q;
    rem_d      = rem_q;
    tail_d     = tail_q;
    if (accept_i) begin
      if (mode_i == MODE_HEADER) begin
        // A new header drops any pending write without a result.
        awaiting_d = 1'b0;
        pend_fc_d  = '0;
        rem_d      = '0;
        tail_d     = '0;
        cmd_push_o = 1'b1;
        if (req_err) begin
          cmd_o.kind     = CMD_ERR;
          cmd_o.end_idx  = '0;
          cmd_o.fin_last = 1'b1;
        end else begin
          cmd_o.kind     = CMD_HDR;
          cmd_o.end_idx  = is_multi ? HDR_LAST_MULTI : HDR_LAST_SINGLE;
          cmd_o.fin_last = !is_multi;
          cmd_o.tid      = transaction_id_i;
          cmd_o.len      = is_multi ? (9'(nbytes_full[7:0]) + 9'd7) : 9'd6;
          cmd_o.unit     = unit_id_i;
          cmd_o.fc       = req_fc;
          cmd_o.off      = off_full[15:0];
          cmd_o.word     = req_word;
          cmd_o.nbytes   = nbytes_full[7:0];
          if (is_multi) begin
            awaiting_d = 1'b1;
            pend_fc_d  = req_fc;
            rem_d      = nbytes_full[7:0];
            tail_d     = (req_fc == FC_WRITE_COILS) ? (item_count_i[2:0] & TAIL_MASK) : 3'd0;
          end
        end
      end else if (awaiting_q && (rem_q != 8'd0)) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = CMD_DATA;
        if (pend_fc_q == FC_WRITE_COILS) begin
          rem_next = rem_q - 8'd1;
          // The final coil byte keeps only the coils the request covers.
          if ((rem_next == 8'd0) && (tail_q != 3'd0)) begin
            coil_byte = coil_byte & ~(8'hFF << tail_q);
          end
          cmd_o.end_idx = 4'd0;
          cmd_o.word    = {8'h00, coil_byte};
        end else begin
          rem_next      = (rem_q >= 8'd2) ? (rem_q - 8'd2) : 8'd0;
          cmd_o.end_idx = 4'd1;
          cmd_o.word    = data_word_i;
        end
        cmd_o.fin_last = (rem_next == 8'd0);
        rem_d          = rem_next;
        if (rem_next == 8'd0) begin
          awaiting_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      pend_fc_q  <= '0;
      rem_q      <= '0;
      tail_q     <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      pend_fc_q  <= pend_fc_d;
      rem_q      <= rem_d;
      tail_q     <= tail_d;
    end
  end

endmodule

>>> rtl/mbtcp_cmdq.sv
// Short command queue that decouples the front end from the byte serializer.
module mbtcp_cmdq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  mbtcp_pkg::cmd_t wr_data_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output mbtcp_pkg::cmd_t rd_data_o,
  output logic            empty_o
);
  import mbtcp_pkg::*;

  localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CntW = $clog2(QDEPTH + 1);

  cmd_t            slots_q [QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(QDEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/mbtcp_back.sv
// Back end: serializes queued commands into frame bytes through an output register.
module mbtcp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  mbtcp_pkg::cmd_t q_data_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [7:0]      frame_byte_o,
  output logic            last_of_frame_o,
  output logic            status_o
);
  import mbtcp_pkg::*;

  cmd_t       cmd_q;
  logic       busy_q;
  logic [3:0] idx_q;
  logic       out_v_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_status_q;

  logic       can_emit, emit, fin, load;
  logic [7:0] byte_d;

  // The output register is free when empty or when its item leaves this cycle.
  assign can_emit = !out_v_q || pop_i;
  assign emit     = busy_q && can_emit;
  assign fin      = (idx_q == cmd_q.end_idx);
  assign load     = !q_empty_i && (!busy_q || (emit && fin));
  assign q_pop_o  = load;

  always_comb begin
    byte_d = 8'h00;
    unique case (cmd_q.kind)
      CMD_ERR: byte_d = 8'h00;
      CMD_HDR: begin
        unique case (idx_q)
          4'd0:    byte_d = cmd_q.tid[15:8];
          4'd1:    byte_d = cmd_q.tid[7:0];
          4'd4:    byte_d = {7'd0, cmd_q.len[8]};
          4'd5:    byte_d = cmd_q.len[7:0];
          4'd6:    byte_d = cmd_q.unit;
          4'd7:    byte_d = {3'd0, cmd_q.fc};
          4'd8:    byte_d = cmd_q.off[15:8];
          4'd9:    byte_d = cmd_q.off[7:0];
          4'd10:   byte_d = cmd_q.word[15:8];
          4'd11:   byte_d = cmd_q.word[7:0];
          4'd12:   byte_d = cmd_q.nbytes;
          default: byte_d = 8'h00;
        endcase
      end
      CMD_DATA: begin
        // A register word goes high byte first; a coil byte is alone.
        if ((cmd_q.end_idx != 4'd0) && (idx_q == 4'd0)) begin
          byte_d = cmd_q.word[15:8];
        end else begin
          byte_d = cmd_q.word[7:0];
        end
      end
      default: byte_d = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= q_data_i;
    end
    if (emit) begin
      out_byte_q   <= byte_d;
      out_last_q   <= fin && cmd_q.fin_last;
      out_status_q <= (cmd_q.kind == CMD_ERR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        if (fin) begin
          busy_q <= 1'b0;
        end
        idx_q <= idx_q + 4'd1;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign empty_o         = !out_v_q;
  assign frame_byte_o    = out_byte_q;
  assign last_of_frame_o = out_last_q;
  assign status_o        = out_status_q;

endmodule

>>> rtl/modbus_tcp_request_framer.sv
// Modbus TCP request framer. A header item (mode 0) is classified into a function code and
// offset and becomes a burst of 12 bytes (functions 1 to 6) or 13 bytes (functions 15 and
// 16, MBAP header, PDU head and byte count), or a single error item; a data item (mode 1)
// for a pending multi-write becomes one coil byte or two register bytes. Items are taken
// one per cycle until the four-entry command queue between the classifier and the
// serializer is full; the serializer sends one result per cycle while results are popped.
// The sustained rate is set by each item's result count: one for errors and coil data, two
// for register data, 12 or 13 for headers. Data items with nothing pending are dropped.
module modbus_tcp_request_framer #(
  parameter int MAX_DATA_BYTES = mbtcp_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic        write_request_i,
  input  logic [19:0] address_i,
  input  logic [15:0] item_count_i,
  input  logic [7:0]  unit_id_i,
  input  logic [15:0] transaction_id_i,
  input  logic [15:0] data_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte_o,
  output logic        last_of_frame_o,
  output logic        status_o
);
  import mbtcp_pkg::*;

  logic cmd_push, q_full, q_empty, q_pop;
  cmd_t cmd_in, cmd_out;

  assign full = q_full;

  mbtcp_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (push && !q_full),
    .mode_i          (mode_i),
    .write_request_i (write_request_i),
    .address_i       (address_i),
    .item_count_i    (item_count_i),
    .unit_id_i       (unit_id_i),
    .transaction_id_i(transaction_id_i),
    .data_word_i     (data_word_i),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  mbtcp_cmdq u_cmdq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cmd_push),
    .wr_data_i(cmd_in),
    .full_o   (q_full),
    .rd_en_i  (q_pop),
    .rd_data_o(cmd_out),
    .empty_o  (q_empty)
  );

  mbtcp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (cmd_out),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .frame_byte_o   (frame_byte_o),
    .last_of_frame_o(last_of_frame_o),
    .status_o       (status_o)
  );

endmodule

>>> rtl/mbtcp_checker.sv
// Port-level checks for the framer, bound to its top level.
module mbtcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] frame_byte_o,
  input logic       last_of_frame_o,
  input logic       status_o
);

  // An error item always closes the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> last_of_frame_o)
    else $error("error item without last_of_frame");

  // An error item carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> (frame_byte_o == 8'h00))
    else $error("error item with nonzero byte");

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(frame_byte_o) && $stable(last_of_frame_o)
                          && $stable(status_o)))
    else $error("waiting result changed");

  // Once reset has been seen at an edge, nothing is offered in the following cycle.
  assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result offered after reset");

endmodule

bind modbus_tcp_request_framer mbtcp_checker u_checker (.*);

>>> verif/tb_modbus_tcp_request_framer.sv
// Self-checking testbench for the Modbus TCP request framer with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_modbus_tcp_request_framer;
  import mbtcp_pkg::*;

  localparam int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int NUM_ITEMS      = 180;

  typedef struct {
    logic        mode;
    logic        wr;
    logic [19:0] address;
    logic [15:0] count;
    logic [7:0]  unit;
    logic [15:0] tid;
    logic [15:0] dw;
  } request_t;

  typedef struct {
    logic [7:0] fbyte;
    logic       last;
    logic       status;
  } frame_out_t;

  typedef enum int {
    AREA_COIL,
    AREA_DISC,
    AREA_INREG,
    AREA_INREG_X,
    AREA_HOLD,
    AREA_HOLD_X
  } area_e;

  class frame_scoreboard;
    frame_out_t  expected_bytes[$];
    int          errors;
    logic        awaiting_data;
    logic [4:0]  pending_fc;
    logic [7:0]  remaining_bytes;
    logic [2:0]  coil_tail;

    function new();
      errors          = 0;
      awaiting_data   = 1'b0;
      pending_fc      = '0;
      remaining_bytes = '0;
      coil_tail       = '0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void add_byte(logic [7:0] fbyte, logic last, logic status);
      frame_out_t b;
      b.fbyte  = fbyte;
      b.last   = last;
      b.status = status;
      expected_bytes.push_back(b);
    endfunction

    function int reject();
      add_byte(8'h00, 1'b1, 1'b1);
      return 1;
    endfunction

    function int frame_header(request_t r);
      logic [4:0]  fc;
      logic [19:0] a;
      logic [15:0] off;
      logic [15:0] word;
      int unsigned nbytes;
      int unsigned len;
      logic        multi;
      a      = r.address;
      nbytes = 0;
      // A new header always drops whatever multi-write was still open.
      awaiting_data   = 1'b0;
      pending_fc      = '0;
      remaining_bytes = '0;
      coil_tail       = '0;
      if (r.count == 0 || int'(r.count) > 8 * MAX_DATA_BYTES) return reject();
      if (a >= ADDR_COIL_LO && a < ADDR_COIL_END) begin
        off = 16'(a - ADDR_COIL_LO);
        fc  = !r.wr ? FC_READ_COILS : (r.count == 1 ? FC_WRITE_COIL : FC_WRITE_COILS);
      end else if (a >= ADDR_DISC_LO && a < ADDR_DISC_END) begin
        if (r.wr) return reject();
        off = 16'(a - ADDR_DISC_LO);
        fc  = FC_READ_DISCRETE;
      end else if ((a >= ADDR_INREG_LO && a <= ADDR_INREG_HI) ||
                   (a >= ADDR_INREG_XLO && a <= ADDR_INREG_XHI)) begin
        if (r.wr) return reject();
        off = (a <= ADDR_INREG_HI) ? 16'(a - ADDR_INREG_LO) : 16'(a - ADDR_INREG_XBASE);
        fc  = FC_READ_INPUT;
      end else if ((a >= ADDR_HOLD_LO && a <= ADDR_HOLD_HI) ||
                   (a >= ADDR_HOLD_XLO && a <= ADDR_HOLD_XHI)) begin
        off = (a <= ADDR_HOLD_HI) ? 16'(a - ADDR_HOLD_LO) : 16'(a - ADDR_HOLD_XBASE);
        fc  = !r.wr ? FC_READ_HOLDING : (r.count == 1 ? FC_WRITE_REGISTER : FC_WRITE_REGISTERS);
      end else begin
        return reject();
      end
      word = r.count;
      if (fc == FC_WRITE_COIL) word = r.dw[0] ? COIL_ON : COIL_OFF;
      else if (fc == FC_WRITE_REGISTER) word = r.dw;
      if (fc == FC_WRITE_COILS) nbytes = (int'(r.count) + 7) / 8;
      else if (fc == FC_WRITE_REGISTERS) nbytes = int'(r.count) * 2;
      if (nbytes > MAX_DATA_BYTES) return reject();
      multi = (fc == FC_WRITE_COILS || fc == FC_WRITE_REGISTERS);
      len   = multi ? nbytes + 7 : 6;
      add_byte(r.tid[15:8], 1'b0, 1'b0);
      add_byte(r.tid[7:0], 1'b0, 1'b0);
      add_byte(8'h00, 1'b0, 1'b0);
      add_byte(8'h00, 1'b0, 1'b0);
      add_byte(8'((len >> 8) & 'hFF), 1'b0, 1'b0);
      add_byte(8'(len & 'hFF), 1'b0, 1'b0);
      add_byte(r.unit, 1'b0, 1'b0);
      add_byte({3'b000, fc}, 1'b0, 1'b0);
      add_byte(off[15:8], 1'b0, 1'b0);
      add_byte(off[7:0], 1'b0, 1'b0);
      add_byte(word[15:8], 1'b0, 1'b0);
      if (!multi) begin
        add_byte(word[7:0], 1'b1, 1'b0);
        return 12;
      end
      add_byte(word[7:0], 1'b0, 1'b0);
      add_byte(8'(nbytes & 'hFF), 1'b0, 1'b0);
      awaiting_data   = 1'b1;
      pending_fc      = fc;
      remaining_bytes = 8'(nbytes & 'hFF);
      coil_tail       = (fc == FC_WRITE_COILS) ? r.count[2:0] & TAIL_MASK : 3'd0;
      return 13;
    endfunction

    function int frame_data(logic [15:0] dw);
      logic [7:0] b;
      if (!awaiting_data || remaining_bytes == 0) return 0;
      if (pending_fc == FC_WRITE_COILS) begin
        b = dw[7:0];
        remaining_bytes = remaining_bytes - 8'd1;
        if (remaining_bytes == 0) begin
          // Only the coils actually requested survive in the final byte.
          if (coil_tail != 0) b = b & ((8'd1 << coil_tail) - 8'd1);
          awaiting_data = 1'b0;
          add_byte(b, 1'b1, 1'b0);
        end else begin
          add_byte(b, 1'b0, 1'b0);
        end
        return 1;
      end
      add_byte(dw[15:8], 1'b0, 1'b0);
      remaining_bytes = (remaining_bytes >= 2) ? remaining_bytes - 8'd2 : 8'd0;
      if (remaining_bytes == 0) begin
        awaiting_data = 1'b0;
        add_byte(dw[7:0], 1'b1, 1'b0);
      end else begin
        add_byte(dw[7:0], 1'b0, 1'b0);
      end
      return 2;
    endfunction

    function int note_request(request_t r);
      if (r.mode == MODE_HEADER) return frame_header(r);
      return frame_data(r.dw);
    endfunction

    function void check_byte(logic [7:0] fbyte, logic last, logic status);
      frame_out_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $error("unexpected item: frame_byte %0h last_of_frame %0b status %0b",
               fbyte, last, status);
        return;
      end
      want = expected_bytes.pop_front();
      if (fbyte !== want.fbyte) begin
        errors++;
        $error("frame_byte: expected %0h, actual %0h", want.fbyte, fbyte);
      end
      if (last !== want.last) begin
        errors++;
        $error("last_of_frame: expected %0b, actual %0b", want.last, last);
      end
      if (status !== want.status) begin
        errors++;
        $error("status: expected %0b, actual %0b", want.status, status);
      end
    endfunction
  endclass

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        push             = 1'b0;
  logic        full;
  logic        mode_i           = 1'b0;
  logic        write_request_i  = 1'b0;
  logic [19:0] address_i        = '0;
  logic [15:0] item_count_i     = '0;
  logic [7:0]  unit_id_i        = '0;
  logic [15:0] transaction_id_i = '0;
  logic [15:0] data_word_i      = '0;
  logic        empty;
  logic        pop              = 1'b0;
  logic [7:0]  frame_byte_o;
  logic        last_of_frame_o;
  logic        status_o;

  frame_scoreboard sb;
  int send_idle_pct = 13;
  int recv_idle_pct = 48;
  int sent_items    = 0;
  int idle_cycles   = 0;

  modbus_tcp_request_framer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .mode_i           (mode_i),
    .write_request_i  (write_request_i),
    .address_i        (address_i),
    .item_count_i     (item_count_i),
    .unit_id_i        (unit_id_i),
    .transaction_id_i (transaction_id_i),
    .data_word_i      (data_word_i),
    .empty            (empty),
    .pop              (pop),
    .frame_byte_o     (frame_byte_o),
    .last_of_frame_o  (last_of_frame_o),
    .status_o         (status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic request_t make_header(logic wr, logic [19:0] addr, logic [15:0] cnt,
                                           logic [7:0] unit, logic [15:0] tid,
                                           logic [15:0] dw);
    request_t r;
    r.mode    = MODE_HEADER;
    r.wr      = wr;
    r.address = addr;
    r.count   = cnt;
    r.unit    = unit;
    r.tid     = tid;
    r.dw      = dw;
    return r;
  endfunction

  // Fields other than the data word are don't-care on a data item, so they get noise.
  function automatic request_t make_data(logic [15:0] dw);
    request_t r;
    r.mode    = MODE_DATA;
    r.wr      = 1'($urandom_range(0, 1));
    r.address = 20'($urandom_range(0, 20'hFFFFF));
    r.count   = 16'($urandom_range(0, 16'hFFFF));
    r.unit    = 8'($urandom_range(0, 8'hFF));
    r.tid     = 16'($urandom_range(0, 16'hFFFF));
    r.dw      = dw;
    return r;
  endfunction

  task automatic send_item(input request_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push             <= 1'b1;
    mode_i           <= r.mode;
    write_request_i  <= r.wr;
    address_i        <= r.address;
    item_count_i     <= r.count;
    unit_id_i        <= r.unit;
    transaction_id_i <= r.tid;
    data_word_i      <= r.dw;
    do @(posedge clk_i); while (full !== 1'b0);
    void'(sb.note_request(r));
    sent_items++;
  endtask

  task automatic random_frame(input bit broken);
    area_e       area;
    logic        wr;
    logic [19:0] addr;
    logic [15:0] cnt;
    int          n_data;
    area = area_e'($urandom_range(0, 5));
    wr   = 1'b0;
    if (area == AREA_COIL || area == AREA_HOLD || area == AREA_HOLD_X)
      wr = 1'($urandom_range(0, 1));
    case (area)
      AREA_COIL:    addr = 20'($urandom_range(ADDR_COIL_LO, ADDR_COIL_END - 1));
      AREA_DISC:    addr = 20'($urandom_range(ADDR_DISC_LO, ADDR_DISC_END - 1));
      AREA_INREG:   addr = 20'($urandom_range(ADDR_INREG_LO, ADDR_INREG_HI));
      AREA_INREG_X: addr = 20'($urandom_range(ADDR_INREG_XLO, ADDR_INREG_XHI));
      AREA_HOLD:    addr = 20'($urandom_range(ADDR_HOLD_LO, ADDR_HOLD_HI));
      default:      addr = 20'($urandom_range(ADDR_HOLD_XLO, ADDR_HOLD_XHI));
    endcase
    // Mostly short frames, with the odd one near the data byte limit.
    if ($urandom_range(0, 39) == 0)
      cnt = (wr && area != AREA_COIL) ? 16'($urandom_range(100, 120))
                                      : 16'($urandom_range(1800, 1920));
    else if (wr && $urandom_range(0, 3) == 0)
      cnt = 16'd1;
    else
      cnt = (area == AREA_COIL) ? 16'($urandom_range(1, 40)) : 16'($urandom_range(1, 10));
    n_data = 0;
    if (wr && cnt > 1) n_data = (area == AREA_COIL) ? (int'(cnt) + 7) / 8 : int'(cnt);
    if (broken) begin
      if (n_data > 0 && $urandom_range(0, 1) == 1) n_data = int'($urandom_range(0, n_data - 1));
      else n_data = n_data + int'($urandom_range(1, 2));
    end
    send_item(make_header(wr, addr, cnt, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))));
    repeat (n_data) send_item(make_data(16'($urandom_range(0, 65535))));
  endtask

  // Result side: random stalls on pop, every accepted item goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_byte(frame_byte_o, last_of_frame_o, status_o);
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int choice;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    send_item(make_data(16'hFFFF));
    send_item(make_header(1'b0, 20'd1, 16'd1, 8'h00, 16'h0000, 16'h0000));
    send_item(make_header(1'b0, 20'd9999, 16'd1920, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_header(1'b0, 20'd40001, 16'd0, 8'h11, 16'h1234, 16'h0000));
    send_item(make_header(1'b0, 20'd40001, 16'd1921, 8'h22, 16'h2345, 16'h0000));
    send_item(make_header(1'b0, 20'd0, 16'd1, 8'h33, 16'h3456, 16'h0000));
    send_item(make_header(1'b0, 20'd10000, 16'd1, 8'h44, 16'h4567, 16'h0000));
    send_item(make_header(1'b0, 20'd10001, 16'd5, 8'h55, 16'h5678, 16'h0000));
    send_item(make_header(1'b1, 20'd19999, 16'd2, 8'h66, 16'h6789, 16'h0000));
    send_item(make_header(1'b0, 20'd30001, 16'd3, 8'h77, 16'h789A, 16'h0000));
    send_item(make_header(1'b0, 20'd365536, 16'd4, 8'h88, 16'h89AB, 16'h0000));
    send_item(make_header(1'b1, 20'd310000, 16'd2, 8'h99, 16'h9ABC, 16'h0000));
    send_item(make_header(1'b0, 20'd465536, 16'd7, 8'hAA, 16'hABCD, 16'h0000));
    send_item(make_header(1'b0, 20'd465537, 16'd7, 8'hBB, 16'hBCDE, 16'h0000));
    send_item(make_header(1'b1, 20'hFFFFF, 16'hFFFF, 8'hCC, 16'hCDEF, 16'hFFFF));
    send_item(make_header(1'b1, 20'd1, 16'd1, 8'h01, 16'h0102, 16'h0001));
    send_item(make_header(1'b1, 20'd9999, 16'd1, 8'h02, 16'h0203, 16'hFFFE));
    send_item(make_header(1'b1, 20'd40001, 16'd1, 8'h03, 16'h0304, 16'hABCD));
    send_item(make_header(1'b1, 20'd49999, 16'd121, 8'h04, 16'h0405, 16'h0000));
    // Ten coils: the high bits of a coil byte and the unused tail bits are dropped.
    send_item(make_header(1'b1, 20'd5, 16'd10, 8'h05, 16'h0506, 16'h0000));
    send_item(make_data(16'hFFAA));
    send_item(make_data(16'hFFFF));
    send_item(make_header(1'b1, 20'd410000, 16'd2, 8'h06, 16'h0607, 16'h0000));
    send_item(make_data(16'h1234));
    send_item(make_data(16'hFEDC));
    // Largest multi-writes, each abandoned by the next header.
    send_item(make_header(1'b1, 20'd9999, 16'd1920, 8'h07, 16'h0708, 16'h0000));
    send_item(make_data(16'h00FF));
    send_item(make_header(1'b1, 20'd49999, 16'd120, 8'h08, 16'h0809, 16'h0000));
    send_item(make_header(1'b0, 20'd49999, 16'd1, 8'h09, 16'h090A, 16'h0000));

    // Random part, until the whole run has sent about the planned number of items.
    while (sent_items < NUM_ITEMS) begin
      if (sent_items < NUM_ITEMS / 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 48;
      end else if (sent_items < 2 * NUM_ITEMS / 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      choice = $urandom_range(0, 99);
      if (choice < 65) begin
        random_frame(1'b0);
      end else if (choice < 80) begin
        random_frame(1'b1);
      end else if ($urandom_range(0, 1) == 1) begin
        send_item(make_data(16'($urandom_range(0, 65535))));
      end else begin
        send_item(make_header(1'($urandom_range(0, 1)), 20'($urandom_range(0, 20'hFFFFF)),
                              16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))));
      end
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // Keep popping a while so that any extra item from the block is caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
